/* hdl/assert_macros.svh */
// Assertion macros for the checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/prsd_pkg.sv */
// Package for the PNM raster sample decoder: types, constants, register codes.
// No dependencies.
package prsd_pkg;
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EWIDTH_W = COL_W + 1;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FMT_ASCII  = 2'd0,
    FMT_BINARY = 2'd1,
    FMT_PACKED = 2'd2,
    FMT_NONE   = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    REG_FORMAT = 3'd0,
    REG_MAX    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_PLANES = 3'd4,
    REG_ALPHA  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    JOB_VALUE = 2'd0,
    JOB_BITS  = 2'd1
  } job_kind_t;

  // Work handed from the front end to the back end.
  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] value;
    logic [7:0]  bits;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DIV   = 2'd1,
    BK_EMIT  = 2'd2,
    BK_BITS  = 2'd3
  } bk_state_t;

  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
endpackage

/* hdl/prsd_if.sv */
// Valid/ready channel interfaces for the decoder.
// Depends on nothing.
interface prsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface prsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sample;
  logic [1:0]  plane_index;
  logic [11:0] column;
  logic        row_end;
  logic        image_end;
  logic        alpha_used;
  logic        last_of_run;
  modport source (output valid, sample, plane_index, column, row_end, image_end,
                  alpha_used, last_of_run, input ready);
  modport sink (input valid, sample, plane_index, column, row_end, image_end,
                alpha_used, last_of_run, output ready);
endinterface

interface prsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/pnm_raster_sample_decoder_top.sv */
// Channel   Dir  Handshake     Payload
// in_       in   valid/ready   data_byte, end_of_stream
// out_      out  valid/ready   sample, plane_index, column, row_end, image_end, ...
// cfg_      in   valid/ready   index, data
// A byte passes the combinational front end into a two-entry queue.
// A scaled sample goes through load, the serial divider's eight steps, then emit;
// a value at or above max_value skips the divider and goes straight to emit.
// A packed byte is loaded, then gives one bit per cycle unless stalled, up to 8 bits.
// Reset is synchronous, active low; cfg_ready is always high.
// Output stalls back up through the queue to in_ready.
// Depends on prsd_pkg, prsd_if, prsd_front, prsd_queue, prsd_back.
module pnm_raster_sample_decoder_top (
  input logic clk,
  input logic rst_n,
  prsd_in_if.sink    in_ch,
  prsd_out_if.source out_ch,
  prsd_cfg_if.sink   cfg_ch
);
  logic [1:0]  fmt_r;
  logic [15:0] max_r;
  logic [12:0] width_r;
  logic [15:0] height_r;
  logic [2:0]  planes_r;
  logic        alpha_r;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  prsd_pkg::job_t fq_job, qb_job;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 2'd1;
      max_r <= 16'd255;
      width_r <= 13'd1;
      height_r <= 16'd1;
      planes_r <= 3'd1;
      alpha_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (prsd_pkg::reg_idx_t'(cfg_ch.index))
        prsd_pkg::REG_FORMAT: fmt_r <= cfg_ch.data[1:0];
        prsd_pkg::REG_MAX:    max_r <= cfg_ch.data;
        prsd_pkg::REG_WIDTH:  width_r <= cfg_ch.data[12:0];
        prsd_pkg::REG_HEIGHT: height_r <= cfg_ch.data;
        prsd_pkg::REG_PLANES: planes_r <= cfg_ch.data[2:0];
        prsd_pkg::REG_ALPHA:  alpha_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  prsd_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data_byte(in_ch.data_byte), .in_end_of_stream(in_ch.end_of_stream),
    .fmt(prsd_pkg::fmt_t'(fmt_r)),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  prsd_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
  );

  prsd_back u_back (
    .clk, .rst_n,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .max_value(max_r), .image_width(width_r), .image_height(height_r),
    .plane_count(planes_r), .has_alpha(alpha_r),
    .o(out_ch)
  );
endmodule

/* hdl/prsd_front.sv */
// Front end: ASCII tokenizer and byte classifier; emits jobs to the queue.
// Depends on prsd_pkg.
module prsd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_end_of_stream,
  input  prsd_pkg::fmt_t       fmt,
  output logic                 job_valid,
  input  logic                 job_ready,
  output prsd_pkg::job_t       job
);
  logic [15:0] acc_r, acc_nxt;
  logic        in_num_r, in_num_nxt;
  logic        in_cmt_r, in_cmt_nxt;
  logic        after_nl_r, after_nl_nxt;
  logic        is_digit;
  logic [19:0] acc_x10;

  assign in_ready = job_ready;
  assign is_digit = (in_data_byte >= prsd_pkg::CH_0) && (in_data_byte <= prsd_pkg::CH_9);
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + {12'd0, in_data_byte - prsd_pkg::CH_0};

  always_comb begin
    acc_nxt = acc_r;
    in_num_nxt = in_num_r;
    in_cmt_nxt = in_cmt_r;
    after_nl_nxt = after_nl_r;
    job_valid = 1'b0;
    job.kind = prsd_pkg::JOB_VALUE;
    job.value = acc_r;
    job.bits = in_data_byte;
    if (in_valid) begin
      if (in_end_of_stream) begin
        if (fmt == prsd_pkg::FMT_ASCII && in_num_r) begin
          job_valid = 1'b1;
          in_num_nxt = 1'b0;
        end
      end else begin
        unique case (fmt)
          prsd_pkg::FMT_ASCII: begin
            if (in_cmt_r) begin
              if (in_data_byte == prsd_pkg::CH_NL) begin
                in_cmt_nxt = 1'b0;
                after_nl_nxt = 1'b1;
              end
            end else if (is_digit) begin
              if (in_num_r) begin
                acc_nxt = (acc_x10 > 20'd65535) ? 16'hffff : acc_x10[15:0];
              end else begin
                acc_nxt = {8'd0, in_data_byte - prsd_pkg::CH_0};
              end
              in_num_nxt = 1'b1;
              after_nl_nxt = 1'b0;
            end else begin
              if (in_num_r) begin
                job_valid = 1'b1;
                in_num_nxt = 1'b0;
              end
              if (in_data_byte == prsd_pkg::CH_HASH && after_nl_r) begin
                in_cmt_nxt = 1'b1;
                after_nl_nxt = 1'b0;
              end else begin
                after_nl_nxt = (in_data_byte == prsd_pkg::CH_NL);
              end
            end
          end
          prsd_pkg::FMT_BINARY: begin
            job_valid = 1'b1;
            job.value = {8'd0, in_data_byte};
          end
          prsd_pkg::FMT_PACKED: begin
            job_valid = 1'b1;
            job.kind = prsd_pkg::JOB_BITS;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      in_num_r <= 1'b0;
      in_cmt_r <= 1'b0;
      after_nl_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      acc_r <= acc_nxt;
      in_num_r <= in_num_nxt;
      in_cmt_r <= in_cmt_nxt;
      after_nl_r <= after_nl_nxt;
    end
  end
endmodule

/* hdl/prsd_queue.sv */
// Short job queue between front and back end.
// Depends on prsd_pkg.
module prsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  prsd_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output prsd_pkg::job_t rd_job
);
  localparam int AW = $clog2(prsd_pkg::QUEUE_DEPTH);
  prsd_pkg::job_t mem_r [prsd_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign wr_ready = (cnt_r != prsd_pkg::QUEUE_DEPTH[AW:0]);
  assign rd_valid = (cnt_r != '0);
  assign rd_job = mem_r[rp_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{AW{1'b0}}, do_wr} - {{AW{1'b0}}, do_rd};
    end
  end
endmodule

/* hdl/prsd_back.sv */
// Back end: serial scaling divider, position counters, output register.
// Depends on prsd_pkg.
module prsd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  prsd_pkg::job_t       job,
  input  logic [15:0]          max_value,
  input  logic [12:0]          image_width,
  input  logic [15:0]          image_height,
  input  logic [2:0]           plane_count,
  input  logic                 has_alpha,
  prsd_out_if.source           o
);
  prsd_pkg::bk_state_t st_r, st_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [16:0] den_r;
  logic [7:0]  quo_r;
  logic [3:0]  step_r;
  logic [7:0]  bits_r;
  logic [2:0]  bitn_r;
  logic        val_r;
  logic [7:0]  val_sample_r;
  logic [11:0] col_r;
  logic [1:0]  pl_r;
  logic [15:0] row_r;
  logic        alpha_r;
  logic [2:0]  eplanes;
  logic [prsd_pkg::EWIDTH_W-1:0] ewidth;
  logic [15:0] eheight;
  logic        last_plane, row_end, image_end, alpha_nxt, emit, out_free;
  logic [7:0]  emit_val;
  logic        emit_last;
  logic [24:0] trial;

  assign eplanes = (plane_count == 3'd0) ? 3'd1 : (plane_count > 3'd4) ? 3'd4 : plane_count;
  assign ewidth = (image_width == 13'd0) ? 13'd1 :
                  (image_width > 13'(prsd_pkg::MAX_WIDTH)) ?
                  13'(prsd_pkg::MAX_WIDTH) : image_width;
  assign eheight = (image_height == 16'd0) ? 16'd1 : image_height;

  assign last_plane = ({1'b0, pl_r} + 3'd1) >= eplanes;
  assign row_end = last_plane && ({1'b0, col_r} + 13'd1 >= ewidth);
  assign image_end = row_end && ({1'b0, row_r} + 17'd1 >= {1'b0, eheight});
  assign out_free = !o.valid || o.ready;

  // Restoring divider: one quotient bit per cycle.
  assign trial = {1'b0, rem_r} - {1'b0, den_r, 7'd0} ;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      prsd_pkg::BK_IDLE: begin
        if (job_valid) begin
          if (job.kind == prsd_pkg::JOB_BITS) st_nxt = prsd_pkg::BK_BITS;
          else if (job.value >= max_value) st_nxt = prsd_pkg::BK_EMIT;
          else st_nxt = prsd_pkg::BK_DIV;
        end
      end
      prsd_pkg::BK_DIV: if (step_r == 4'd7) st_nxt = prsd_pkg::BK_EMIT;
      prsd_pkg::BK_EMIT: if (out_free) st_nxt = prsd_pkg::BK_IDLE;
      prsd_pkg::BK_BITS: if (out_free && (row_end || bitn_r == 3'd7)) st_nxt = prsd_pkg::BK_IDLE;
      default: st_nxt = prsd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (st_r == prsd_pkg::BK_IDLE);
    emit = 1'b0;
    emit_val = val_sample_r;
    emit_last = 1'b1;
    rem_nxt = rem_r;
    unique case (st_r)
      prsd_pkg::BK_EMIT: emit = out_free;
      prsd_pkg::BK_BITS: begin
        emit = out_free;
        emit_val = bits_r[7] ? 8'hff : 8'h00;
        emit_last = row_end || (bitn_r == 3'd7);
      end
      prsd_pkg::BK_DIV: rem_nxt = trial[24] ? {rem_r[22:0], 1'b0} : {trial[22:0], 1'b0};
      default: ;
    endcase
    alpha_nxt = alpha_r || (has_alpha && last_plane && emit_val != 8'hff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= prsd_pkg::BK_IDLE;
      o.valid <= 1'b0;
      col_r <= '0;
      pl_r <= '0;
      row_r <= '0;
      alpha_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (o.ready) o.valid <= 1'b0;
      if (emit) begin
        o.valid <= 1'b1;
        alpha_r <= alpha_nxt;
        if (last_plane) begin
          pl_r <= '0;
          if ({1'b0, col_r} + 13'd1 >= ewidth) begin
            col_r <= '0;
            row_r <= ({1'b0, row_r} + 17'd1 >= {1'b0, eheight}) ? 16'd0 : row_r + 16'd1;
          end else begin
            col_r <= col_r + 12'd1;
          end
        end else begin
          pl_r <= pl_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o.sample <= emit_val;
      o.plane_index <= pl_r;
      o.column <= col_r;
      o.row_end <= row_end;
      o.image_end <= image_end;
      o.alpha_used <= alpha_nxt;
      o.last_of_run <= emit_last;
    end
    unique case (st_r)
      prsd_pkg::BK_IDLE: begin
        step_r <= '0;
        bitn_r <= '0;
        bits_r <= job.bits;
        den_r <= {1'b0, max_value} + 17'd1;
        rem_r <= {job.value, 8'd0};
        quo_r <= '0;
        val_sample_r <= 8'hff;
      end
      prsd_pkg::BK_DIV: begin
        // Quotient < 256, so eight steps starting at weight 128 suffice.
        rem_r <= rem_nxt;
        quo_r <= {quo_r[6:0], ~trial[24]};
        step_r <= step_r + 4'd1;
        if (step_r == 4'd7) val_sample_r <= {quo_r[6:0], ~trial[24]};
      end
      prsd_pkg::BK_BITS: begin
        if (out_free) begin
          bits_r <= {bits_r[6:0], 1'b0};
          bitn_r <= bitn_r + 3'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

/* hdl/prsd_checker.sv */
// Port-level checker for the decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module prsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_sample,
  input logic       out_row_end,
  input logic       out_image_end,
  input logic       out_alpha_used,
  input logic       out_last_of_run
);
  `ASSERT_IMPL(a_img_row, clk, rst_n, out_valid && out_image_end, out_row_end)
  `ASSERT_IMPL(a_row_last, clk, rst_n, out_valid && out_row_end && out_sample != 8'h00 && out_sample != 8'hff, out_last_of_run)
  `ASSERT_NEXT(a_alpha_sticky, clk, rst_n, out_valid && out_ready && out_alpha_used, !out_valid || out_alpha_used)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample))
endmodule

bind pnm_raster_sample_decoder_top prsd_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_sample(out_ch.sample),
  .out_row_end(out_ch.row_end), .out_image_end(out_ch.image_end),
  .out_alpha_used(out_ch.alpha_used), .out_last_of_run(out_ch.last_of_run)
);

/* bench/tb_pnm_raster_sample_decoder_top.sv */
// Self-checking bench for pnm_raster_sample_decoder_top: a directed table and then random
// byte streams in all sample formats, with every result checked against an in-bench predictor.
// Depends on prsd_pkg, prsd_if and the decoder RTL.
module tb_pnm_raster_sample_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  sample;
    logic [1:0]  plane_index;
    logic [11:0] column;
    logic        row_end;
    logic        image_end;
    logic        alpha_used;
    logic        last_of_run;
  } sample_t;

  typedef enum bit {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    prsd_pkg::reg_idx_t idx;
    logic [15:0]        val;
    logic               eos;
    bit                 chk;
    logic [7:0]         want;
  } row_t;

  localparam int TOTAL_ITEMS = 270;
  localparam int SETTLE_CYCLES = 120;

  logic clk;
  logic rst_n;
  prsd_in_if  in_ch();
  prsd_out_if out_ch();
  prsd_cfg_if cfg_ch();

  pnm_raster_sample_decoder_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Predictor copy of the registers and decode state.
  int unsigned fmt_r, max_r, width_r, height_r, planes_r, alpha_r;
  int unsigned acc, col_n, plane_n, row_n;
  bit in_num, in_cmt, after_nl, alpha_seen;

  sample_t pending_samples[$];
  int errors = 0;
  int items_sent = 0;
  bit calm = 0;
  int stall_left = 0;
  // First sample caused by the most recent request, for the directed table.
  bit run_has = 0;
  logic [7:0] run_first = '0;

  task automatic report(string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic int unsigned scale_sample(int unsigned r);
    if (r >= max_r) return 255;
    return (r * 256) / (max_r + 1);
  endfunction

  // Places one sample at the current position and advances; returns the row end flag.
  function automatic bit place_sample(int unsigned value);
    int unsigned planes, width, height;
    bit last_plane, row_end, image_end;
    sample_t s;
    planes = (planes_r == 0) ? 1 : (planes_r > 4 ? 4 : planes_r);
    width = (width_r == 0) ? 1 :
            (width_r > prsd_pkg::MAX_WIDTH ? prsd_pkg::MAX_WIDTH : width_r);
    height = (height_r == 0) ? 1 : height_r;
    last_plane = plane_n + 1 >= planes;
    row_end = last_plane && (col_n + 1 >= width);
    image_end = row_end && (row_n + 1 >= height);
    if (alpha_r != 0 && last_plane && value != 255) alpha_seen = 1;
    s.sample = value[7:0];
    s.plane_index = plane_n[1:0];
    s.column = col_n[11:0];
    s.row_end = row_end;
    s.image_end = image_end;
    s.alpha_used = alpha_seen;
    s.last_of_run = 0;
    pending_samples.push_back(s);
    plane_n++;
    if (plane_n >= planes) begin
      plane_n = 0;
      col_n++;
      if (col_n >= width) begin
        col_n = 0;
        row_n++;
        if (row_n >= height) row_n = 0;
      end
    end
    return row_end;
  endfunction

  function automatic void decode_text(logic [7:0] c);
    int unsigned v;
    if (in_cmt) begin
      if (c == prsd_pkg::CH_NL) begin
        in_cmt = 0;
        after_nl = 1;
      end
      return;
    end
    if (c >= prsd_pkg::CH_0 && c <= prsd_pkg::CH_9) begin
      if (in_num) begin
        v = acc * 10 + (c - prsd_pkg::CH_0);
        acc = (v > 65535) ? 65535 : v;
      end else begin
        acc = c - prsd_pkg::CH_0;
        in_num = 1;
      end
      after_nl = 0;
      return;
    end
    if (in_num) begin
      in_num = 0;
      void'(place_sample(scale_sample(acc)));
    end
    if (c == prsd_pkg::CH_HASH && after_nl) begin
      in_cmt = 1;
      after_nl = 0;
    end else begin
      after_nl = (c == prsd_pkg::CH_NL);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] c, logic eos);
    int base;
    base = pending_samples.size();
    if (eos) begin
      if (fmt_r == prsd_pkg::FMT_ASCII && in_num) begin
        in_num = 0;
        void'(place_sample(scale_sample(acc)));
      end
    end else if (fmt_r == prsd_pkg::FMT_ASCII) begin
      decode_text(c);
    end else if (fmt_r == prsd_pkg::FMT_BINARY) begin
      void'(place_sample(scale_sample(c)));
    end else if (fmt_r == prsd_pkg::FMT_PACKED) begin
      for (int b = 7; b >= 0; b--) begin
        if (place_sample(c[b] ? 255 : 0)) break;
      end
    end
    run_has = (pending_samples.size() > base);
    if (run_has) begin
      run_first = pending_samples[base].sample;
      pending_samples[pending_samples.size() - 1].last_of_run = 1;
    end
  endfunction

  function automatic void apply_reg(prsd_pkg::reg_idx_t idx, logic [15:0] v);
    case (idx)
      prsd_pkg::REG_FORMAT: fmt_r = v[1:0];
      prsd_pkg::REG_MAX:    max_r = v;
      prsd_pkg::REG_WIDTH:  width_r = v[12:0];
      prsd_pkg::REG_HEIGHT: height_r = v;
      prsd_pkg::REG_PLANES: planes_r = v[2:0];
      prsd_pkg::REG_ALPHA:  alpha_r = v[0];
      default: ;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("pnm_raster_sample_decoder_top verification failed");
    $finish;
  end

  // Result side: random stall bursts, none started in the closing stretch.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        report($sformatf("unexpected sample %0d", out_ch.sample));
      end else begin
        e = pending_samples.pop_front();
        if (out_ch.sample !== e.sample)
          report($sformatf("sample %0d, want %0d", out_ch.sample, e.sample));
        if (out_ch.plane_index !== e.plane_index)
          report($sformatf("plane %0d, want %0d", out_ch.plane_index, e.plane_index));
        if (out_ch.column !== e.column)
          report($sformatf("column %0d, want %0d", out_ch.column, e.column));
        if (out_ch.row_end !== e.row_end)
          report($sformatf("row_end %b, want %b", out_ch.row_end, e.row_end));
        if (out_ch.image_end !== e.image_end)
          report($sformatf("image_end %b, want %b", out_ch.image_end, e.image_end));
        if (out_ch.alpha_used !== e.alpha_used)
          report($sformatf("alpha_used %b, want %b", out_ch.alpha_used, e.alpha_used));
        if (out_ch.last_of_run !== e.last_of_run)
          report($sformatf("last_of_run %b, want %b", out_ch.last_of_run, e.last_of_run));
      end
    end
  end

  // Sends one byte request; returns at the edge where it was taken.
  task automatic send_byte(logic [7:0] b, logic eos);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, eos);
    items_sent++;
  endtask

  // Registers change only once all results are out and the pipeline has drained.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(prsd_pkg::reg_idx_t idx, logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, v);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_reg(prsd_pkg::reg_idx_t idx);
    case (idx)
      prsd_pkg::REG_FORMAT: begin
        if ($urandom_range(0, 9) == 0) return 16'(prsd_pkg::FMT_NONE);
        return 16'($urandom_range(0, 2));
      end
      prsd_pkg::REG_MAX: begin
        case ($urandom_range(0, 5))
          0: return 16'd0;
          1: return 16'd1;
          2: return 16'd65535;
          3: return 16'd255;
          default: return 16'($urandom_range(0, 65535));
        endcase
      end
      prsd_pkg::REG_WIDTH: begin
        case ($urandom_range(0, 9))
          0: return 16'd4096;
          1: return 16'($urandom_range(4097, 8191));
          2: return 16'd0;
          3: return 16'($urandom_range(8192, 65535));
          default: return 16'($urandom_range(1, 9));
        endcase
      end
      prsd_pkg::REG_HEIGHT: begin
        if ($urandom_range(0, 7) == 0) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 4));
      end
      prsd_pkg::REG_PLANES: return 16'($urandom_range(0, 7));
      default: return 16'($urandom_range(0, 1));
    endcase
  endfunction

  // Pushes one decimal token with its separator, a comment line, an end of stream or a noise byte.
  task automatic send_text_token();
    int digits;
    int kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind == 1) begin
      send_byte(prsd_pkg::CH_NL, 1'b0);
      send_byte(prsd_pkg::CH_HASH, 1'b0);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
      send_byte(prsd_pkg::CH_NL, 1'b0);
    end else if (kind == 2) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      repeat (digits) send_byte(prsd_pkg::CH_0 + 8'($urandom_range(0, 9)), 1'b0);
      case ($urandom_range(0, 4))
        0: send_byte(prsd_pkg::CH_NL, 1'b0);
        1: send_byte(8'h09, 1'b0);
        2: send_byte(prsd_pkg::CH_HASH, 1'b0);
        default: send_byte(8'h20, 1'b0);
      endcase
    end
  endtask

  row_t plan[] = '{
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h00, 1'b0, 1'b1, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'hff, 1'b0, 1'b1, 8'd255},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h80, 1'b0, 1'b1, 8'd128},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h5a, 1'b1, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_MAX,    16'd0, 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h07, 1'b0, 1'b1, 8'd255},
    '{ROW_CFG,  prsd_pkg::REG_MAX,    16'd65535, 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'hfe, 1'b0, 1'b1, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_FORMAT, 16'(prsd_pkg::FMT_NONE), 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h12, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_FORMAT, 16'(prsd_pkg::FMT_PACKED), 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_WIDTH,  16'd3, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_HEIGHT, 16'd2, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_PLANES, 16'd2, 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'ha5, 1'b0, 1'b1, 8'd255},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h3c, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_PLANES, 16'd0, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_WIDTH,  16'd0, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_HEIGHT, 16'd0, 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h81, 1'b0, 1'b1, 8'd255},
    '{ROW_CFG,  prsd_pkg::REG_PLANES, 16'd7, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_WIDTH,  16'd5000, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_HEIGHT, 16'd65535, 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h0f, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_FORMAT, 16'(prsd_pkg::FMT_ASCII), 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_MAX,    16'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_WIDTH,  16'd2, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_PLANES, 16'd2, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_HEIGHT, 16'd1, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  prsd_pkg::REG_ALPHA,  16'd1, 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "1", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "2", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, " ", 1'b0, 1'b1, 8'd12},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h0a, 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "#", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "7", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'h0a, 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "2", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "0", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "#", 1'b0, 1'b1, 8'd20},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "7", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "0", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "0", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "0", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "0", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, ",", 1'b0, 1'b1, 8'd255},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, "4", 1'b0, 1'b0, 8'd0},
    '{ROW_BYTE, prsd_pkg::REG_FORMAT, 16'ha7, 1'b1, 1'b1, 8'd4}
  };

  initial begin
    int burst;
    prsd_pkg::reg_idx_t r;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = prsd_pkg::REG_FORMAT;
    cfg_ch.data = '0;
    fmt_r = prsd_pkg::FMT_BINARY; max_r = 255; width_r = 1; height_r = 1;
    planes_r = 1; alpha_r = 0;
    acc = 0; in_num = 0; in_cmt = 0; after_nl = 0;
    col_n = 0; plane_n = 0; row_n = 0; alpha_seen = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i > 0 && plan[i-1].kind == ROW_BYTE) settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_byte(plan[i].val[7:0], plan[i].eos);
        if (plan[i].chk && (!run_has || run_first !== plan[i].want))
          report($sformatf("table row %0d does not give %0d", i, plan[i].want));
      end
    end

    while (items_sent < TOTAL_ITEMS) begin
      settle();
      r = r.first();
      forever begin
        write_reg(r, pick_reg(r));
        if (r == r.last()) break;
        r = r.next();
      end
      burst = items_sent + $urandom_range(15, 30);
      while (items_sent < burst) begin
        calm = (items_sent > TOTAL_ITEMS - 40);
        if (fmt_r == prsd_pkg::FMT_ASCII) begin
          send_text_token();
        end else begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("pnm_raster_sample_decoder_top verification clean");
    end else begin
      $display("pnm_raster_sample_decoder_top verification failed");
    end
    $finish;
  end
endmodule
